### rtl/core/lcnc_pkg.sv
package lcnc_pkg;

   localparam int CARD_W        = 63;
   localparam int COUNT_W       = 5;
   localparam int BRAND_W       = 2;
   localparam int DIGIT_W       = 4;
   localparam int NUM_DIGITS    = 19;
   localparam int BCD_W         = NUM_DIGITS * DIGIT_W;
   localparam int BITS_PER_STEP = 4;
   localparam int BIN_W         = 64;
   localparam int CONV_STEPS    = BIN_W / BITS_PER_STEP;
   localparam int STEP_W        = 5;

   localparam logic [DIGIT_W-1:0] RADIX         = 4'd10;
   localparam logic [DIGIT_W-1:0] DABBLE_THRESH = 4'd5;
   localparam logic [DIGIT_W-1:0] DABBLE_ADJ    = 4'd3;

   localparam logic [COUNT_W-1:0] LEN_SIXTEEN  = 5'd16;
   localparam logic [COUNT_W-1:0] LEN_FIFTEEN  = 5'd15;
   localparam logic [COUNT_W-1:0] LEN_THIRTEEN = 5'd13;

   // leading pairs split into their two decimal digits
   localparam logic [DIGIT_W-1:0] VISA_LEAD   = 4'd4;
   localparam logic [DIGIT_W-1:0] MC_LEAD     = 4'd5;
   localparam logic [DIGIT_W-1:0] MC_LOW      = 4'd1;
   localparam logic [DIGIT_W-1:0] MC_HIGH     = 4'd5;
   localparam logic [DIGIT_W-1:0] AMEX_LEAD   = 4'd3;
   localparam logic [DIGIT_W-1:0] AMEX_SEC_A  = 4'd4;
   localparam logic [DIGIT_W-1:0] AMEX_SEC_B  = 4'd7;

   localparam logic [BRAND_W-1:0] BRAND_INVALID = 2'd0;
   localparam logic [BRAND_W-1:0] BRAND_VISA    = 2'd1;
   localparam logic [BRAND_W-1:0] BRAND_MC      = 2'd2;
   localparam logic [BRAND_W-1:0] BRAND_AMEX    = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CONV   = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   typedef struct packed {
      logic load;
      logic conv;
      logic scan;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic conv_last;
      logic scan_last;
   } stat_type;

endpackage

### rtl/core/lcnc_if.sv
interface lcnc_req_if;
   logic                        valid;
   logic                        ready;
   logic [lcnc_pkg::CARD_W-1:0] card_number;

   modport source (output valid, output card_number, input ready);
   modport sink (input valid, input card_number, output ready);
endinterface

interface lcnc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         luhn_ok;
   logic [lcnc_pkg::COUNT_W-1:0] digit_count;
   logic [lcnc_pkg::BRAND_W-1:0] brand;

   modport source (output valid, output luhn_ok, output digit_count, output brand,
                   input ready);
   modport sink (input valid, input luhn_ok, input digit_count, input brand,
                 output ready);
endinterface

### rtl/core/lcnc_ctrl.sv
module lcnc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  lcnc_pkg::stat_type stat,
   output lcnc_pkg::cmd_type  cmd
);
   import lcnc_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.conv = 1'b1;
            if (stat.conv_last) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output register can take the word
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.finish) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/core/lcnc_dp.sv
module lcnc_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  lcnc_pkg::cmd_type            cmd,
   output lcnc_pkg::stat_type           stat,
   input  logic [lcnc_pkg::CARD_W-1:0]  card_number,
   output logic                         luhn_ok,
   output logic [lcnc_pkg::COUNT_W-1:0] digit_count,
   output logic [lcnc_pkg::BRAND_W-1:0] brand
);
   import lcnc_pkg::*;

   logic [BIN_W-1:0]   bin_ff, bin_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [DIGIT_W-1:0] mod_ff, mod_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [DIGIT_W-1:0] lead_ff, lead_in;
   logic [DIGIT_W-1:0] second_ff, second_in;
   logic [DIGIT_W-1:0] prev_ff, prev_in;
   logic               ok_ff;
   logic [COUNT_W-1:0] dcount_ff;
   logic [BRAND_W-1:0] brand_ff;

   logic [BCD_W-1:0]   dabble;
   logic [DIGIT_W-1:0] digit;
   logic [DIGIT_W:0]   doubled;
   logic [DIGIT_W-1:0] contrib;
   logic [DIGIT_W:0]   mod_sum;
   logic               final_ok;
   logic [BRAND_W-1:0] final_brand;

   assign stat.conv_last = (step_ff == STEP_W'(CONV_STEPS - 1));
   assign stat.scan_last = (step_ff == STEP_W'(NUM_DIGITS - 1));

   // binary to decimal, four input bits per cycle
   always_comb begin
      logic [DIGIT_W-1:0] nib;
      dabble = bcd_ff;
      for (int k = 0; k < BITS_PER_STEP; k++) begin
         for (int j = 0; j < NUM_DIGITS; j++) begin
            nib = dabble[j*DIGIT_W +: DIGIT_W];
            if (nib >= DABBLE_THRESH) nib = nib + DABBLE_ADJ;
            dabble[j*DIGIT_W +: DIGIT_W] = nib;
         end
         dabble = {dabble[BCD_W-2:0], bin_ff[BIN_W-1-k]};
      end
   end

   // Luhn digit: rightmost digit is position one, even positions are doubled
   assign digit   = bcd_ff[DIGIT_W-1:0];
   assign doubled = {digit, 1'b0};
   always_comb begin
      if (!step_ff[0]) begin
         contrib = digit;
      end else if (doubled >= {1'b0, RADIX}) begin
         contrib = DIGIT_W'(doubled - {1'b0, RADIX - 4'd1});
      end else begin
         contrib = doubled[DIGIT_W-1:0];
      end
      mod_sum = {1'b0, mod_ff} + {1'b0, contrib};
      if (mod_sum >= {1'b0, RADIX}) mod_sum = mod_sum - {1'b0, RADIX};
   end

   always_comb begin
      bin_in    = bin_ff;
      bcd_in    = bcd_ff;
      step_in   = step_ff;
      mod_in    = mod_ff;
      count_in  = count_ff;
      lead_in   = lead_ff;
      second_in = second_ff;
      prev_in   = prev_ff;
      if (cmd.load) begin
         bin_in    = {{(BIN_W - CARD_W){1'b0}}, card_number};
         bcd_in    = '0;
         step_in   = '0;
         mod_in    = '0;
         count_in  = '0;
         lead_in   = '0;
         second_in = '0;
         prev_in   = '0;
      end else if (cmd.conv) begin
         bin_in  = bin_ff << BITS_PER_STEP;
         bcd_in  = dabble;
         step_in = stat.conv_last ? '0 : step_ff + 1'b1;
      end else if (cmd.scan) begin
         bcd_in  = bcd_ff >> DIGIT_W;
         step_in = step_ff + 1'b1;
         mod_in  = mod_sum[DIGIT_W-1:0];
         prev_in = digit;
         // track the most significant nonzero digit and the one below it
         if (digit != '0) begin
            count_in  = COUNT_W'(step_ff) + 1'b1;
            lead_in   = digit;
            second_in = prev_ff;
         end
      end
   end

   always_comb begin
      final_ok    = (mod_ff == '0);
      final_brand = BRAND_INVALID;
      if (final_ok) begin
         if ((count_ff == LEN_SIXTEEN || count_ff == LEN_THIRTEEN) && lead_ff == VISA_LEAD)
            final_brand = BRAND_VISA;
         else if (count_ff == LEN_SIXTEEN && lead_ff == MC_LEAD &&
                  second_ff >= MC_LOW && second_ff <= MC_HIGH)
            final_brand = BRAND_MC;
         else if (count_ff == LEN_FIFTEEN && lead_ff == AMEX_LEAD &&
                  (second_ff == AMEX_SEC_A || second_ff == AMEX_SEC_B))
            final_brand = BRAND_AMEX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff    <= bin_in;
      bcd_ff    <= bcd_in;
      mod_ff    <= mod_in;
      count_ff  <= count_in;
      lead_ff   <= lead_in;
      second_ff <= second_in;
      prev_ff   <= prev_in;
      if (cmd.finish) begin
         ok_ff     <= final_ok;
         dcount_ff <= count_ff;
         brand_ff  <= final_brand;
      end
   end

   assign luhn_ok     = ok_ff;
   assign digit_count = dcount_ff;
   assign brand       = brand_ff;

endmodule

### rtl/core/luhn_card_number_classifier_unit.sv
// Flow: the accepted number goes through the shared binary-to-decimal shifter,
// four bits per step, then the one-digit-per-cycle Luhn scan, then classification
// into the output register once that register is free.
// A new card number is accepted only after the last one reaches the output
// register; a finished word waits there while the next number is accepted.
// Reset: synchronous, active high; clears the controller state and rsp valid.
module luhn_card_number_classifier_unit (
   input logic         clock,
   input logic         reset,
   lcnc_req_if.sink    req_ch,
   lcnc_rsp_if.source  rsp_ch
);
   import lcnc_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   lcnc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lcnc_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .card_number (req_ch.card_number),
      .luhn_ok     (rsp_ch.luhn_ok),
      .digit_count (rsp_ch.digit_count),
      .brand       (rsp_ch.brand)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("accepted a new word while one is in flight");

   a_fail_is_invalid: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.luhn_ok) |-> (rsp_ch.brand == BRAND_INVALID))
      else $error("brand reported on a failed Luhn check");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.digit_count <= COUNT_W'(NUM_DIGITS)))
      else $error("digit count out of range");

   a_conv_to_scan: assert property (@(posedge clock) disable iff (reset)
      (cmd.conv && stat.conv_last) |=> cmd.scan)
      else $error("scan did not follow conversion");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.conv, cmd.scan, cmd.finish}))
      else $error("conflicting datapath commands");

endmodule
